[rtl/fbh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbh_pkg
// Shared constants, types and the FNV-1a absorb step for the bucket hash unit.
// ----------------------------------------------------------------------------
package fbh_pkg;

    localparam int unsigned INDEX_BITS_DEF = 24;
    localparam int unsigned HASH_W         = 64;
    localparam int unsigned HALF_W         = 32;
    localparam int unsigned TSIZE_W        = 25;
    localparam int unsigned CFG_IDX_W      = 1;
    localparam int unsigned STEP_W         = 7;

    localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'b1;

    localparam logic [TSIZE_W-1:0] TSIZE_RESET = 25'd1024;

    localparam logic [HASH_W-1:0] BASIS64 = 64'hCBF2_9CE4_8422_2325;
    localparam logic [HALF_W-1:0] BASIS32 = 32'h811C_9DC5;

    localparam logic [STEP_W-1:0] STEPS_WIDE   = 7'd64;
    localparam logic [STEP_W-1:0] STEPS_NARROW = 7'd32;

    typedef struct packed {
        logic start;
        logic wide;
    } t_div_req;

    function automatic logic [HASH_W-1:0] basis_for(input logic wide);
        basis_for = wide ? BASIS64 : {{(HASH_W-HALF_W){1'b0}}, BASIS32};
    endfunction

    // prime64 = 2^40 + 0x1B3, prime32 = 2^24 + 0x193
    function automatic logic [HASH_W-1:0] absorb(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b,
                                                 input logic wide);
        logic [HASH_W-1:0] x;
        logic [HALF_W-1:0] y;
        x = h ^ {{(HASH_W-8){1'b0}}, b};
        y = x[HALF_W-1:0];
        if (wide) begin
            absorb = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
                   + (x << 1) + x;
        end else begin
            absorb = {{(HASH_W-HALF_W){1'b0}},
                      (y << 24) + (y << 8) + (y << 7) + (y << 4) + (y << 1) + y};
        end
    endfunction

endpackage

[rtl/fbh_item_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbh_item_if
// Input channel: key bytes and end-of-key markers.
// ----------------------------------------------------------------------------
interface fbh_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

[rtl/fbh_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbh_result_if
// Output channel: full hash and bucket index of one key.
// ----------------------------------------------------------------------------
interface fbh_result_if #(
    parameter int unsigned INDEX_BITS = fbh_pkg::INDEX_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [63:0]           full_hash;
    logic [INDEX_BITS-1:0] bucket_index;

    modport source (output valid, output full_hash, output bucket_index, input ready);
    modport sink   (input valid, input full_hash, input bucket_index, output ready);
endinterface

[rtl/fbh_mod_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbh_mod_unit
// Restoring bit-serial remainder of the hash by the bucket count.
// ----------------------------------------------------------------------------
module fbh_mod_unit #(
    parameter int unsigned INDEX_BITS = fbh_pkg::INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fbh_pkg::t_div_req     i_req,
    input  logic [63:0]           i_dividend,
    input  logic [INDEX_BITS:0]   i_divisor,
    output logic                  o_done,
    output logic [INDEX_BITS-1:0] o_rem
);
    import fbh_pkg::*;

    localparam int unsigned DW = INDEX_BITS + 1;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [HASH_W-1:0] r_quo;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_div;
    logic              r_zero;

    logic [DW:0]       w_trial;
    logic [DW:0]       w_diff;
    logic [DW-1:0]     n_rem;

    assign w_trial = {r_rem, r_quo[HASH_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign n_rem   = (w_trial >= {1'b0, r_div}) ? w_diff[DW-1:0] : w_trial[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.wide ? STEPS_WIDE : STEPS_NARROW;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo  <= i_req.wide ? i_dividend : {i_dividend[HALF_W-1:0], {HALF_W{1'b0}}};
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            r_quo <= r_quo << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_zero ? '0 : r_rem[INDEX_BITS-1:0];

endmodule

[rtl/fnv1a_bucket_hash_unit.sv]
`timescale 1ns / 1ps
// A key byte is absorbed in the cycle it is accepted, one byte per cycle while idle.
// An end-of-key transaction runs the bit-serial remainder unit for 32 steps
// (32-bit mode) or 64 steps (64-bit mode); the remainder is captured, the result is
// registered when the output slot frees, and no input is taken until then.
// Synchronous active-low reset: 32-bit mode, table size 1024, 32-bit offset basis.
// ----------------------------------------------------------------------------
// fnv1a_bucket_hash_unit
// Byte-serial FNV-1a hash (32 or 64 bit) with reduction to a bucket index.
// ----------------------------------------------------------------------------
module fnv1a_bucket_hash_unit #(
    parameter int unsigned INDEX_BITS = fbh_pkg::INDEX_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fbh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fbh_pkg::TSIZE_W-1:0]    i_cfg_data,
    fbh_item_if.sink                       i_item,
    fbh_result_if.source                   o_result
);
    import fbh_pkg::*;

    localparam int unsigned CMP_W = (INDEX_BITS + 1 > TSIZE_W) ? INDEX_BITS + 1 : TSIZE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic                  r_wide;
    logic [TSIZE_W-1:0]    r_table_size;
    logic [HASH_W-1:0]     r_hash;
    logic [HASH_W-1:0]     r_full;
    logic [INDEX_BITS-1:0] r_idx;
    logic                  r_out_valid;
    logic [HASH_W-1:0]     r_out_hash;
    logic [INDEX_BITS-1:0] r_out_idx;

    logic                  w_accept;
    logic                  w_slot_free;
    logic [HASH_W-1:0]     w_full;
    logic [CMP_W-1:0]      w_ts_ext;
    logic [CMP_W-1:0]      w_cap;
    logic [CMP_W-1:0]      w_div_ext;
    t_div_req              w_req;
    logic                  w_done;
    logic [INDEX_BITS-1:0] w_rem;

    assign i_item.ready = (r_state == ST_IDLE);
    assign w_accept     = i_item.valid && (r_state == ST_IDLE);
    assign w_slot_free  = !r_out_valid || o_result.ready;

    assign w_full    = r_wide ? r_hash : {{(HASH_W-HALF_W){1'b0}}, r_hash[HALF_W-1:0]};
    assign w_ts_ext  = CMP_W'(r_table_size);
    assign w_cap     = CMP_W'(1) << INDEX_BITS;
    assign w_div_ext = (w_ts_ext > w_cap) ? w_cap : w_ts_ext;

    assign w_req.start = w_accept && i_item.kind;
    assign w_req.wide  = r_wide;

    fbh_mod_unit #(
        .INDEX_BITS (INDEX_BITS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_dividend (w_full),
        .i_divisor  (w_div_ext[INDEX_BITS:0]),
        .o_done     (w_done),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_req.start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_wide       <= 1'b0;
            r_table_size <= TSIZE_RESET;
            r_hash       <= basis_for(1'b0);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDE_MODE: begin
                        r_wide <= i_cfg_data[0];
                        r_hash <= basis_for(i_cfg_data[0]);
                    end
                    REG_TABLE_SIZE: begin
                        r_table_size <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end else if (w_accept) begin
                r_hash <= i_item.kind ? basis_for(r_wide) : absorb(r_hash, i_item.data_byte, r_wide);
            end
            if (r_state == ST_HOLD && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req.start) begin
            r_full <= w_full;
        end
        if (w_done) begin
            r_idx <= w_rem;
        end
        if (r_state == ST_HOLD && w_slot_free) begin
            r_out_hash <= r_full;
            r_out_idx  <= r_idx;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.full_hash    = r_out_hash;
    assign o_result.bucket_index = r_out_idx;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte-serial key hashing check for fnv1a_bucket_hash_unit. A directed table
// covers empty keys, byte extremes, both hash widths, zero, unit and oversized
// table sizes, and register writes over a partial key. Random keys with random
// bytes follow, over several register settings and sender/receiver idling
// patterns. Every hash is compared with a local FNV-1a model or a table value.
// ----------------------------------------------------------------------------
module testbench;

    import fbh_pkg::*;

    localparam int unsigned IDX_BITS     = INDEX_BITS_DEF;
    localparam logic        KIND_BYTE    = 1'b0;
    localparam logic        KIND_END     = 1'b1;
    localparam logic [63:0] FNV_PRIME64  = 64'd1099511628211;
    localparam logic [31:0] FNV_PRIME32  = 32'd16777619;
    localparam logic [24:0] BUCKET_CAP   = 25'h100_0000;
    localparam int          SETTLE_CYCLES = 70;
    localparam int          DRAIN_LIMIT  = 20000;
    localparam int          NUM_PHASES   = 8;
    localparam int          PHASE_ITEMS  = 57;
    localparam int          NUM_ROWS     = 29;

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_op;

    typedef struct packed {
        logic [63:0]         full;
        logic [IDX_BITS-1:0] bucket;
    } t_hash_result;

    typedef struct packed {
        t_row_op                op;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic                   kind;
        logic [TSIZE_W-1:0]     value;
        logic                   typed;
        t_hash_result           known;
    } t_key_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [TSIZE_W-1:0]   cfg_data;

    fbh_item_if                             item_bus ();
    fbh_result_if #(.INDEX_BITS(IDX_BITS))  result_bus ();

    fnv1a_bucket_hash_unit #(.INDEX_BITS(IDX_BITS)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_bus),
        .o_result   (result_bus)
    );

    logic               mode_wide;
    logic [TSIZE_W-1:0] tbl_size;
    logic [63:0]        run_hash;

    t_hash_result pending_hashes[$];
    int           err_count;
    int           tx_idle_pct;
    int           rx_stall_pct;

    t_key_row key_rows [0:NUM_ROWS-1] = '{
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_END,  25'h0,        1'b1, '{64'h811C_9DC5, 24'd453}},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_BYTE, 25'h00,       1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_BYTE, 25'hFF,       1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_END,  25'hFF,       1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_BYTE, 25'hAA,       1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_BYTE, 25'h55,       1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_BYTE, 25'h01,       1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_BYTE, 25'h80,       1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_END,  25'h00,       1'b0, '0},
        '{ROW_WRITE, REG_TABLE_SIZE, KIND_BYTE, 25'h0,        1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_END,  25'h5A,       1'b1, '{64'h811C_9DC5, 24'd0}},
        '{ROW_WRITE, REG_TABLE_SIZE, KIND_BYTE, 25'h1,        1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_BYTE, 25'h7F,       1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_END,  25'h00,       1'b0, '0},
        '{ROW_WRITE, REG_WIDE_MODE,  KIND_BYTE, 25'h1,        1'b0, '0},
        '{ROW_WRITE, REG_TABLE_SIZE, KIND_BYTE, 25'h1FF_FFFF, 1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_END,  25'hA5,       1'b1,
          '{64'hCBF2_9CE4_8422_2325, 24'h22_2325}},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_BYTE, 25'hFF,       1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_BYTE, 25'h00,       1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_END,  25'hFF,       1'b0, '0},
        '{ROW_WRITE, REG_TABLE_SIZE, KIND_BYTE, 25'h100_0000, 1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_BYTE, 25'h41,       1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_END,  25'h00,       1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_BYTE, 25'h13,       1'b0, '0},
        '{ROW_WRITE, REG_WIDE_MODE,  KIND_BYTE, 25'h0,        1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_END,  25'h00,       1'b1, '{64'h811C_9DC5, 24'h1C_9DC5}},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_BYTE, 25'h42,       1'b0, '0},
        '{ROW_WRITE, REG_TABLE_SIZE, KIND_BYTE, 25'd1000,     1'b0, '0},
        '{ROW_ITEM,  REG_WIDE_MODE,  KIND_END,  25'h00,       1'b0, '0}
    };

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [63:0] offset_basis(input logic wide);
        offset_basis = wide ? BASIS64 : {32'd0, BASIS32};
    endfunction

    function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b,
                                               input logic wide);
        logic [63:0] x;
        logic [31:0] y;
        x = h ^ {56'd0, b};
        y = x[31:0] * FNV_PRIME32;
        fnv_absorb = wide ? x * FNV_PRIME64 : {32'd0, y};
    endfunction

    function automatic t_hash_result fnv_finish(input logic [63:0] h, input logic wide,
                                                input logic [TSIZE_W-1:0] tsize);
        t_hash_result r;
        logic [63:0]  divisor;
        r.full  = wide ? h : {32'd0, h[31:0]};
        divisor = {39'd0, (tsize > BUCKET_CAP) ? BUCKET_CAP : tsize};
        r.bucket = (divisor == 64'd0) ? '0 : IDX_BITS'(r.full % divisor);
        fnv_finish = r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // Wait for every hash to arrive, then let the block settle.
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        item_bus.valid <= 1'b0;
        while (pending_hashes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_hashes.size() != 0) begin
            report_mismatch($sformatf("%0d hash results never arrived",
                                      pending_hashes.size()));
            pending_hashes.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [TSIZE_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == REG_WIDE_MODE) begin
            mode_wide = value[0];
            run_hash  = offset_basis(mode_wide);
        end else if (idx == REG_TABLE_SIZE) begin
            tbl_size = value;
        end
    endtask

    task automatic send_item(input logic k, input logic [7:0] b, input logic typed,
                             input t_hash_result known);
        t_hash_result exp_hash;
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            item_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        item_bus.valid     <= 1'b1;
        item_bus.kind      <= k;
        item_bus.data_byte <= b;
        do @(posedge i_clk); while (!item_bus.ready);
        if (k == KIND_BYTE) begin
            run_hash = fnv_absorb(run_hash, b, mode_wide);
        end else begin
            exp_hash = typed ? known : fnv_finish(run_hash, mode_wide, tbl_size);
            pending_hashes.insert(pending_hashes.size(), exp_hash);
            run_hash = offset_basis(mode_wide);
        end
    endtask

    always @(negedge i_clk) begin
        result_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        t_hash_result want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (pending_hashes.size() == 0) begin
                report_mismatch($sformatf("unexpected hash %h bucket %h",
                                          result_bus.full_hash, result_bus.bucket_index));
            end else begin
                want = pending_hashes.pop_front();
                if (result_bus.full_hash !== want.full)
                    report_mismatch($sformatf("full_hash %h, want %h",
                                              result_bus.full_hash, want.full));
                if (result_bus.bucket_index !== want.bucket)
                    report_mismatch($sformatf("bucket_index %h, want %h",
                                              result_bus.bucket_index, want.bucket));
            end
        end
    end

    initial begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [TSIZE_W-1:0] tsize_pick;
        int                 sent;
        int                 key_len;
        err_count          = 0;
        tx_idle_pct        = 0;
        rx_stall_pct       = 0;
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = REG_WIDE_MODE;
        cfg_data           = '0;
        item_bus.valid     = 1'b0;
        item_bus.kind      = KIND_BYTE;
        item_bus.data_byte = 8'd0;
        result_bus.ready   = 1'b0;
        mode_wide          = 1'b0;
        tbl_size           = TSIZE_RESET;
        run_hash           = offset_basis(1'b0);

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            if (key_rows[r].op == ROW_WRITE) begin
                drain_results();
                write_reg(key_rows[r].reg_idx, key_rows[r].value);
            end else begin
                send_item(key_rows[r].kind, key_rows[r].value[7:0], key_rows[r].typed,
                          key_rows[r].known);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
                default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
            endcase
            case (ph)
                0: tsize_pick = 25'd1;
                1: tsize_pick = 25'h1FF_FFFF;
                2: tsize_pick = 25'd0;
                3: tsize_pick = BUCKET_CAP;
                4: tsize_pick = TSIZE_W'($urandom_range(64, 1));
                5: tsize_pick = TSIZE_W'($urandom);
                6: tsize_pick = TSIZE_RESET;
                default: tsize_pick = TSIZE_W'($urandom_range(32'h100_0000, 1));
            endcase
            if (ph % 2 == 0)
                write_reg(REG_WIDE_MODE, TSIZE_W'((ph / 2) % 2));
            write_reg(REG_TABLE_SIZE, tsize_pick);

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(99) < 10) begin
                    send_item(1'($urandom), 8'($urandom), 1'b0, '0);
                    sent++;
                end else begin
                    key_len = ($urandom_range(99) < 80) ? $urandom_range(8, 0)
                                                        : $urandom_range(40, 9);
                    for (int i = 0; i < key_len; i++)
                        send_item(KIND_BYTE, 8'($urandom), 1'b0, '0);
                    send_item(KIND_END, 8'($urandom), 1'b0, '0);
                    sent += key_len + 1;
                end
            end
        end

        drain_results();
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
